FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, idle while reset is held
`define LSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked on the rising clock, idle while reset is held
`define LSD_ASSERT_IMP(label, pre, post, msg) \
  `LSD_ASSERT(label, (pre) |-> (post), msg)

`endif

FILE: hdl/lsd_pkg.sv
package lsd_pkg;

  localparam int unsigned NumElectrodes = 6;
  localparam int unsigned DriveBit      = 3;
  localparam int unsigned TickW         = 16;
  localparam int unsigned CntW          = 4;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [CfgIdxW-1:0] REG_MONITOR_ENABLE = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_MONITOR_MASK   = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_CHECK_INTERVAL = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_COUNT = 8'd3;

  localparam logic                     RST_ENABLE   = 1'b0;
  localparam logic [NumElectrodes-1:0] RST_MASK     = 6'd55;
  localparam logic [TickW-1:0]         RST_INTERVAL = 16'd1000;
  localparam logic [CntW-1:0]          RST_DEBOUNCE = 4'd3;

  localparam logic [NumElectrodes-1:0] DRIVE_CLEAR = ~(6'd1 << DriveBit);

  typedef struct packed {
    logic                     strobe;
    logic [NumElectrodes-1:0] raw;
  } lsd_sample_t;

endpackage

FILE: hdl/lsd_interval.sv
module lsd_interval
  import lsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             enable_i,
  input  logic [TickW-1:0] interval_i,
  output logic             sample_o
);

  logic [TickW-1:0] tick_q, tick_d;
  logic [TickW:0]   tick_inc;
  logic             hit;

  assign tick_inc = {1'b0, tick_q} + {{TickW{1'b0}}, 1'b1};
  assign hit      = tick_inc >= {1'b0, interval_i};
  assign sample_o = enable_i && hit;

  always_comb begin
    tick_d = tick_q;
    if (advance_i && enable_i) begin
      tick_d = hit ? '0 : tick_inc[TickW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else begin
      tick_q <= tick_d;
    end
  end

  `include "assert_macros.svh"

  `LSD_ASSERT(a_tick_wraps, (advance_i && sample_o) |=> (tick_q == '0), "tick not cleared")
  `LSD_ASSERT(a_tick_holds, (!enable_i) |=> $stable(tick_q), "tick moved while disabled")

endmodule

FILE: hdl/lsd_debounce.sv
module lsd_debounce
  import lsd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lsd_sample_t              smp_i,
  input  logic [NumElectrodes-1:0] mask_i,
  input  logic [CntW-1:0]          dbc_i,
  output logic [NumElectrodes-1:0] off_o
);

  logic [NumElectrodes-1:0] off_q, off_d;
  logic [CntW-1:0]          cnt_q [NumElectrodes];
  logic [CntW-1:0]          cnt_d [NumElectrodes];
  logic [CntW-1:0]          cnt_inc [NumElectrodes];

  always_comb begin
    off_d = off_q;
    for (int i = 0; i < NumElectrodes; i++) begin
      cnt_inc[i] = cnt_q[i] + {{(CntW-1){1'b0}}, 1'b1};
      cnt_d[i]   = cnt_q[i];
      if (smp_i.strobe && mask_i[i]) begin
        if (smp_i.raw[i] == off_q[i]) begin
          cnt_d[i] = '0;
        end else if (cnt_inc[i] >= dbc_i) begin
          off_d[i] = smp_i.raw[i];
          cnt_d[i] = '0;
        end else begin
          cnt_d[i] = cnt_inc[i];
        end
      end
    end
  end

  assign off_o = off_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      for (int i = 0; i < NumElectrodes; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      off_q <= off_d;
      for (int i = 0; i < NumElectrodes; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  `include "assert_macros.svh"

  `LSD_ASSERT_IMP(a_state_frozen, !smp_i.strobe, (off_d == off_q), "state moved without sample")
  `LSD_ASSERT(a_drive_clear, (mask_i[DriveBit] == 1'b0) |-> (off_d[DriveBit] == off_q[DriveBit]), "drive bit changed")

endmodule

FILE: hdl/leadoff_status_debouncer.sv
// Lead-off status debouncer for six electrodes. Each transfer on the slave stream is one
// tick with the raw lead-off bits; each tick yields exactly one result transfer on the
// master stream. A tick is held in the input register; then the interval counter and the six
// debounce counters update as the result register is loaded, and a new tick is taken every
// cycle while the result side keeps up.
// The configuration port is always ready; write it only while no tick is in flight.
module leadoff_status_debouncer
  import lsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // raw_off_bits[5:0], zero pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // off_status[5:0], alarm[6], sampled[7]
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic                     enable_q;
  logic [NumElectrodes-1:0] mask_q;
  logic [TickW-1:0]         interval_q;
  logic [CntW-1:0]          dbc_q;

  logic                     in_valid_q;
  logic [NumElectrodes-1:0] raw_q;
  logic                     out_valid_q;
  logic [7:0]               out_data_q;

  logic                     advance;
  logic                     sample;
  logic [NumElectrodes-1:0] eff_mask;
  logic [NumElectrodes-1:0] off_next;
  logic [NumElectrodes-1:0] status;
  lsd_sample_t              smp;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign eff_mask      = mask_q & DRIVE_CLEAR;
  assign smp.strobe    = advance && sample;
  assign smp.raw       = raw_q;
  assign status        = off_next & eff_mask;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= RST_ENABLE;
      mask_q     <= RST_MASK;
      interval_q <= RST_INTERVAL;
      dbc_q      <= RST_DEBOUNCE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MONITOR_ENABLE: enable_q   <= cfg_data_i[0];
        REG_MONITOR_MASK:   mask_q     <= cfg_data_i[NumElectrodes-1:0];
        REG_CHECK_INTERVAL: interval_q <= cfg_data_i[TickW-1:0];
        REG_DEBOUNCE_COUNT: dbc_q      <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      raw_q <= s_axis_tdata[NumElectrodes-1:0];
    end
    if (advance) begin
      out_data_q <= {sample, |status, status};
    end
  end

  lsd_interval u_interval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .enable_i   (enable_q),
    .interval_i (interval_q),
    .sample_o   (sample)
  );

  lsd_debounce u_debounce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp),
    .mask_i (eff_mask),
    .dbc_i  (dbc_q),
    .off_o  (off_next)
  );

  `include "assert_macros.svh"

  `LSD_ASSERT_IMP(a_sampled_needs_enable, (m_axis_tvalid && m_axis_tdata[7]), enable_q, "sampled while disabled")
  `LSD_ASSERT(a_result_follows, advance |=> out_valid_q, "result lost")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import lsd_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 8'd7;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomTicks   = 1550;

  typedef struct packed {
    logic                     sampled;
    logic                     alarm;
    logic [NumElectrodes-1:0] off;
  } lead_status_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;  // raw_off_bits[5:0], zero pad
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [7:0]          m_axis_tdata;   // off_status[5:0], alarm[6], sampled[7]
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  leadoff_status_debouncer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the debouncer: configuration and state
  logic                     mon_en;
  logic [NumElectrodes-1:0] mon_mask;
  logic [TickW-1:0]         chk_interval;
  logic [CntW-1:0]          deb_count;
  logic [TickW-1:0]         tick_cnt;
  logic [NumElectrodes-1:0] off_state;
  logic [CntW-1:0]          change_cnt [NumElectrodes];

  logic [NumElectrodes-1:0] tick_queue [$];
  lead_status_t             due_status [$];

  int unsigned err_count  = 0;
  int unsigned idle_count = 0;
  logic        in_fire    = 1'b0;
  logic        out_fire   = 1'b0;
  logic        cfg_fire   = 1'b0;

  function automatic lead_status_t debounce_tick(input logic [NumElectrodes-1:0] raw);
    lead_status_t             st;
    logic [NumElectrodes-1:0] eff;
    int unsigned              nxt;
    eff = mon_mask & DRIVE_CLEAR;
    st.sampled = 1'b0;
    if (mon_en) begin
      nxt = tick_cnt + 1;
      if (nxt >= chk_interval) begin
        tick_cnt = '0;
        st.sampled = 1'b1;
        for (int i = 0; i < NumElectrodes; i++) begin
          if (eff[i]) begin
            if (raw[i] == off_state[i]) begin
              change_cnt[i] = '0;
            end else begin
              change_cnt[i] = change_cnt[i] + 1'b1;
              if (change_cnt[i] >= deb_count) begin
                off_state[i] = raw[i];
                change_cnt[i] = '0;
              end
            end
          end
        end
      end else begin
        tick_cnt = nxt[TickW-1:0];
      end
    end
    st.off = off_state & eff;
    st.alarm = |st.off;
    return st;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // monitor: config shadow, prediction, result check, watchdog
  always @(posedge clk_i) begin
    lead_status_t exp_st;
    lead_status_t pred_st;
    cfg_fire = cfg_valid_i && cfg_ready_o;
    in_fire  = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (cfg_fire) begin
        case (cfg_index_i)
          REG_MONITOR_ENABLE: mon_en = cfg_data_i[0];
          REG_MONITOR_MASK:   mon_mask = cfg_data_i[NumElectrodes-1:0];
          REG_CHECK_INTERVAL: chk_interval = cfg_data_i[TickW-1:0];
          REG_DEBOUNCE_COUNT: deb_count = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        pred_st = debounce_tick(s_axis_tdata[NumElectrodes-1:0]);
        due_status.insert(due_status.size(), pred_st);
      end
      if (out_fire) begin
        if (due_status.size() == 0) begin
          report_mismatch("result transfer with nothing pending", m_axis_tdata, 0);
        end else begin
          exp_st = due_status.pop_front();
          if (m_axis_tdata[5:0] != exp_st.off)
            report_mismatch("off_status", m_axis_tdata[5:0], exp_st.off);
          if (m_axis_tdata[6] != exp_st.alarm)
            report_mismatch("alarm", m_axis_tdata[6], exp_st.alarm);
          if (m_axis_tdata[7] != exp_st.sampled)
            report_mismatch("sampled", m_axis_tdata[7], exp_st.sampled);
        end
      end
      if (cfg_fire || in_fire || out_fire) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // tick driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (burst_left > 0 && tick_queue.size() > 0) begin
        s_axis_tdata <= {2'b00, tick_queue.pop_front()};
        s_axis_tvalid <= 1'b1;
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (burst_left == 0 && gap_left > 0) gap_left--;
      end
    end
  end

  // result side stall pattern
  logic [15:0] ready_pat  = 16'hFFFF;
  int unsigned pat_left   = 0;
  logic [3:0]  pat_pos    = '0;

  always @(negedge clk_i) begin
    if (pat_left == 0) begin
      ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      pat_left = $urandom_range(16, 200);
    end
    pat_left--;
    m_axis_tready <= ready_pat[pat_pos];
    pat_pos = pat_pos + 1'b1;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (tick_queue.size() != 0 || s_axis_tvalid || due_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_tick(input logic [NumElectrodes-1:0] raw);
    tick_queue.insert(tick_queue.size(), raw);
  endtask

  // steady runs of one level, broken up by stray ticks
  task automatic queue_runs(input int unsigned count);
    logic [NumElectrodes-1:0] level;
    int unsigned              run;
    int unsigned              k;
    k = 0;
    while (k < count) begin
      level = 6'($urandom_range(0, 63));
      run = $urandom_range(1, 24);
      while (run > 0 && k < count) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_tick(6'($urandom_range(0, 63)));
        end else begin
          queue_tick(level);
        end
        run--;
        k++;
      end
    end
  endtask

  initial begin
    int unsigned rand_done;
    int unsigned n;
    mon_en = RST_ENABLE;
    mon_mask = RST_MASK;
    chk_interval = RST_INTERVAL;
    deb_count = RST_DEBOUNCE;
    tick_cnt = '0;
    off_state = '0;
    for (int i = 0; i < NumElectrodes; i++) change_cnt[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // monitoring off after reset
    queue_tick(6'h3F);
    queue_tick(6'h00);
    wait_idle();

    // adopt at once, every tick samples, drive electrode included in mask
    write_reg(REG_MONITOR_ENABLE, 16'd1);
    write_reg(REG_MONITOR_MASK, 16'd63);
    write_reg(REG_CHECK_INTERVAL, 16'd0);
    write_reg(REG_DEBOUNCE_COUNT, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_tick(6'h3F);
    queue_tick(6'h00);
    queue_tick(6'h2A);
    wait_idle();

    // nothing monitored
    write_reg(REG_MONITOR_MASK, 16'd0);
    write_reg(REG_CHECK_INTERVAL, 16'd1);
    queue_tick(6'h3F);
    wait_idle();

    // debounce lowered below the running counters
    write_reg(REG_MONITOR_MASK, 16'd63);
    write_reg(REG_DEBOUNCE_COUNT, 16'd15);
    repeat (4) queue_tick(6'h15);
    wait_idle();
    write_reg(REG_DEBOUNCE_COUNT, 16'd2);
    queue_tick(6'h15);
    wait_idle();

    // interval lowered below the tick count
    write_reg(REG_CHECK_INTERVAL, 16'hFFFF);
    repeat (3) queue_tick(6'h3F);
    wait_idle();
    write_reg(REG_CHECK_INTERVAL, 16'd2);
    queue_tick(6'h3F);
    wait_idle();

    // monitoring switched off with state held
    write_reg(REG_MONITOR_ENABLE, 16'd0);
    queue_tick(6'h00);
    wait_idle();
    write_reg(REG_MONITOR_ENABLE, 16'd1);
    write_reg(REG_MONITOR_MASK, 16'd0);
    queue_tick(6'h00);
    wait_idle();

    rand_done = 0;
    while (rand_done < RandomTicks) begin
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_MONITOR_ENABLE, ($urandom_range(0, 7) != 0) ? 16'd1 : 16'd0);
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_MONITOR_MASK, 16'($urandom_range(0, 63)));
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          7:       write_reg(REG_CHECK_INTERVAL, 16'($urandom_range(5, 40)));
          8:       write_reg(REG_CHECK_INTERVAL, 16'd0);
          9:       write_reg(REG_CHECK_INTERVAL, 16'($urandom_range(41, 65535)));
          default: write_reg(REG_CHECK_INTERVAL, 16'($urandom_range(1, 4)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 3) == 0)
          write_reg(REG_DEBOUNCE_COUNT, 16'($urandom_range(0, 15)));
        else
          write_reg(REG_DEBOUNCE_COUNT, 16'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 15) == 0)
        write_reg(REG_UNUSED, 16'($urandom()));
      n = $urandom_range(20, 120);
      queue_runs(n);
      rand_done += n;
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (due_status.size() != 0)
      report_mismatch("results never delivered", 0, due_status.size());
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/lsd_pkg.sv
hdl/lsd_interval.sv
hdl/lsd_debounce.sv
hdl/leadoff_status_debouncer.sv
tb/tb.sv
